// ===== design/srgb_to_cielab_top_macros.svh =====
// assertion macros for the srgb to cielab design files, used by the lab stage
`ifndef SRGB_TO_CIELAB_TOP_MACROS_SVH
`define SRGB_TO_CIELAB_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SCL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/scl_pkg.sv =====
// shared types, constants and rom builders for the srgb to cielab pipeline
package scl_pkg;

  localparam int unsigned Lanes        = 3;
  localparam int unsigned LinBits      = 17;
  localparam int unsigned CoefBits     = 16;
  localparam int unsigned ProdBits     = CoefBits + LinBits;
  localparam int unsigned TBits        = 17;
  localparam int unsigned FBits        = 17;
  localparam int unsigned CbrtStepBits = 7;
  localparam int unsigned CbrtIdxBits  = 10;
  localparam int unsigned EvenDepth    = 513;
  localparam int unsigned OddDepth     = 512;
  localparam int unsigned EvenAddrBits = 10;
  localparam int unsigned OddAddrBits  = 9;
  localparam int unsigned InterpBits   = 24;
  localparam int unsigned LinNumBits   = 26;
  localparam int unsigned RecipBits    = 27;
  localparam int unsigned RecipShift   = 38;
  localparam int unsigned QuotBits     = LinNumBits + RecipBits;
  localparam int unsigned KappaBits    = 32;
  localparam int unsigned LabBits      = 28;

  // floor(n / 3132) for n below 2^26 as a multiply by a rounded-up reciprocal
  localparam logic [RecipBits-1:0] LinRecip =
    RecipBits'(((64'd1 << RecipShift) + 64'd3131) / 64'd3132);
  localparam logic [KappaBits-1:0] KappaMul  = 32'd24389;
  localparam logic [KappaBits-1:0] LinLimit  = 32'd14155776;
  localparam logic [LinNumBits-1:0] LinOffset = 26'd28313118;

  typedef logic [LinBits-1:0]  lin_t;
  typedef logic [TBits-1:0]    tval_t;
  typedef logic [FBits-1:0]    fval_t;
  typedef lin_t  lin_vec_t  [Lanes];
  typedef tval_t tval_vec_t [Lanes];
  typedef fval_t fval_vec_t [Lanes];

  typedef logic [CoefBits-1:0] coef_row_t [Lanes];
  typedef coef_row_t coef_mat_t [Lanes];

  // srgb to xyz matrix, rows divided by the d65 white, q16
  localparam coef_mat_t XyzCoef = '{
    '{16'd28439, 16'd24656, 16'd12440},
    '{16'd13938, 16'd46869, 16'd4730},
    '{16'd1164,  16'd7174,  16'd57194}
  };

  typedef fval_t cbrt_even_t [EvenDepth];
  typedef fval_t cbrt_odd_t  [OddDepth];

  // fifth power in q30 with truncated products
  function automatic logic [63:0] pow5_q30(input logic [63:0] w);
    logic [63:0] w2;
    logic [63:0] w4;
    w2 = (w * w) >> 30;
    w4 = (w2 * w2) >> 30;
    return (w4 * w) >> 30;
  endfunction

  // linearised channel value in q16 for code v of full scale m
  function automatic lin_t gamma_entry(input logic [63:0] v, input logic [63:0] m);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] t;
    logic [63:0] s;
    if (v * 64'd100000 <= 64'd4045 * m) begin
      num = v * 64'd6553600 + 64'd646 * m;
      den = 64'd1292 * m;
      lo  = 64'd0;
      hi  = 64'd131071;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (mid * den <= num) lo = mid;
        else hi = mid - 64'd1;
      end
    end else begin
      den = 64'd1055 * m;
      num = ((64'd1000 * v + 64'd55 * m) << 30) + (den >> 1);
      lo  = 64'd0;
      hi  = 64'd1 << 31;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (mid * den <= num) lo = mid;
        else hi = mid - 64'd1;
      end
      t = lo;
      if (t > (64'd1 << 30)) t = 64'd1 << 30;
      s  = (t * t) >> 30;
      lo = 64'd0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5_q30(mid) <= s) lo = mid;
        else hi = mid - 64'd1;
      end
      lo = (((s * lo) >> 30) + 64'd8192) >> 14;
    end
    return LinBits'(lo);
  endfunction

  // rounded cube root of k/512 in q16
  function automatic fval_t cbrt_entry(input logic [63:0] k);
    logic [63:0] n;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] q;
    n  = k << 39;
    lo = 64'd0;
    hi = 64'd131071;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (mid * mid * mid <= n) lo = mid;
      else hi = mid - 64'd1;
    end
    q = 64'd2 * lo + 64'd1;
    if (64'd8 * n > q * q * q) lo = lo + 64'd1;
    return FBits'(lo);
  endfunction

  function automatic cbrt_even_t build_cbrt_even();
    cbrt_even_t tbl;
    for (int unsigned i = 0; i < EvenDepth; i++) begin
      tbl[i] = cbrt_entry(64'(2 * i));
    end
    return tbl;
  endfunction

  function automatic cbrt_odd_t build_cbrt_odd();
    cbrt_odd_t tbl;
    for (int unsigned i = 0; i < OddDepth; i++) begin
      tbl[i] = cbrt_entry(64'(2 * i + 1));
    end
    return tbl;
  endfunction

endpackage

// ===== design/scl_gamma.sv =====
// gamma linearisation stage: one registered rom read per channel
module scl_gamma #(
  parameter int unsigned ChannelBits = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic                valid_o,
  output scl_pkg::lin_vec_t   lin_o
);

  localparam int unsigned Depth    = 1 << ChannelBits;
  localparam int unsigned WideBits = (ChannelBits > 8) ? ChannelBits : 8;

  typedef scl_pkg::lin_t gamma_tbl_t [Depth];

  function automatic gamma_tbl_t build_gamma();
    gamma_tbl_t tbl;
    for (int unsigned v = 0; v < Depth; v++) begin
      tbl[v] = scl_pkg::gamma_entry(64'(v), (64'd1 << ChannelBits) - 64'd1);
    end
    return tbl;
  endfunction

  localparam gamma_tbl_t GammaRom = build_gamma();

  logic [WideBits-1:0]    wide [scl_pkg::Lanes];
  logic [ChannelBits-1:0] addr [scl_pkg::Lanes];
  logic                   valid_q;
  scl_pkg::lin_vec_t      lin_q;

  // only the low channel bits address the table
  assign wide[0] = WideBits'(red_i);
  assign wide[1] = WideBits'(green_i);
  assign wide[2] = WideBits'(blue_i);

  always_comb begin
    for (int i = 0; i < scl_pkg::Lanes; i++) begin
      addr[i] = wide[i][ChannelBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // rom read, one copy per lane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < scl_pkg::Lanes; i++) begin
        lin_q[i] <= GammaRom[addr[i]];
      end
    end
  end

  assign valid_o = valid_q;
  assign lin_o   = lin_q;

endmodule

// ===== design/scl_matrix.sv =====
// rgb to normalised xyz: products in one stage, sums and rounding in the next
module scl_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  scl_pkg::lin_vec_t  lin_i,
  output logic               valid_o,
  output scl_pkg::tval_vec_t t_o
);

  typedef logic [scl_pkg::ProdBits-1:0] prod_t;
  typedef prod_t prod_row_t [scl_pkg::Lanes];

  localparam int unsigned SumBits = scl_pkg::ProdBits + 2;

  prod_row_t          prod_q [scl_pkg::Lanes];
  logic               prod_valid_q;
  scl_pkg::tval_vec_t t_d;
  scl_pkg::tval_vec_t t_q;
  logic               t_valid_q;
  logic [SumBits-1:0] sum [scl_pkg::Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      t_valid_q    <= 1'b0;
    end else if (en_i) begin
      prod_valid_q <= valid_i;
      t_valid_q    <= prod_valid_q;
    end
  end

  // nine coefficient products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < scl_pkg::Lanes; r++) begin
        for (int c = 0; c < scl_pkg::Lanes; c++) begin
          prod_q[r][c] <= scl_pkg::ProdBits'(scl_pkg::XyzCoef[r][c]) *
                          scl_pkg::ProdBits'(lin_i[c]);
        end
      end
    end
  end

  // row sums, rounded back to q16
  always_comb begin
    for (int r = 0; r < scl_pkg::Lanes; r++) begin
      sum[r] = SumBits'(prod_q[r][0]) + SumBits'(prod_q[r][1]) +
               SumBits'(prod_q[r][2]) + SumBits'(32768);
      t_d[r] = sum[r][32:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_d;
    end
  end

  assign valid_o = t_valid_q;
  assign t_o     = t_q;

endmodule

// ===== design/scl_compand.sv =====
// lab companding per component: cube root rom with interpolation, or the linear segment
module scl_compand (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  scl_pkg::tval_vec_t t_i,
  output logic               valid_o,
  output scl_pkg::fval_vec_t f_o
);

  localparam scl_pkg::cbrt_even_t CbrtEven = scl_pkg::build_cbrt_even();
  localparam scl_pkg::cbrt_odd_t  CbrtOdd  = scl_pkg::build_cbrt_odd();

  logic [scl_pkg::CbrtIdxBits-1:0]   idx       [scl_pkg::Lanes];
  logic [scl_pkg::EvenAddrBits-1:0]  even_addr [scl_pkg::Lanes];
  logic [scl_pkg::OddAddrBits-1:0]   odd_addr  [scl_pkg::Lanes];
  logic [scl_pkg::KappaBits-1:0]     kprod     [scl_pkg::Lanes];

  // stage one of three: rom reads and the kappa product
  scl_pkg::fval_t                    even_q    [scl_pkg::Lanes];
  scl_pkg::fval_t                    odd_q     [scl_pkg::Lanes];
  logic                              kodd_q    [scl_pkg::Lanes];
  logic [scl_pkg::CbrtStepBits-1:0]  frac_q    [scl_pkg::Lanes];
  logic [scl_pkg::LinNumBits-1:0]    num_q     [scl_pkg::Lanes];
  logic                              seg_a_q   [scl_pkg::Lanes];
  logic                              valid_a_q;

  // stage two: interpolation product and reciprocal product
  scl_pkg::fval_t                    e0        [scl_pkg::Lanes];
  scl_pkg::fval_t                    e1        [scl_pkg::Lanes];
  scl_pkg::fval_t                    step      [scl_pkg::Lanes];
  scl_pkg::fval_t                    base_q    [scl_pkg::Lanes];
  logic [scl_pkg::InterpBits-1:0]    interp_q  [scl_pkg::Lanes];
  logic [scl_pkg::QuotBits-1:0]      quot_q    [scl_pkg::Lanes];
  logic                              seg_b_q   [scl_pkg::Lanes];
  logic                              valid_b_q;

  // stage three: result
  logic [scl_pkg::InterpBits-1:0]    interp_rnd [scl_pkg::Lanes];
  scl_pkg::fval_vec_t                f_d;
  scl_pkg::fval_vec_t                f_q;
  logic                              valid_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  // even and odd banks hold neighbouring entries, so both reads happen at once
  always_comb begin
    for (int l = 0; l < scl_pkg::Lanes; l++) begin
      idx[l]       = t_i[l][scl_pkg::TBits-1:scl_pkg::CbrtStepBits];
      even_addr[l] = scl_pkg::EvenAddrBits'(
                       ({1'b0, idx[l]} + (scl_pkg::CbrtIdxBits + 1)'(1)) >> 1);
      odd_addr[l]  = idx[l][scl_pkg::CbrtIdxBits-1:1];
      kprod[l]     = scl_pkg::KappaBits'(t_i[l]) * scl_pkg::KappaMul;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < scl_pkg::Lanes; l++) begin
        even_q[l]  <= CbrtEven[even_addr[l]];
        odd_q[l]   <= CbrtOdd[odd_addr[l]];
        kodd_q[l]  <= idx[l][0];
        frac_q[l]  <= t_i[l][scl_pkg::CbrtStepBits-1:0];
        num_q[l]   <= kprod[l][scl_pkg::LinNumBits-1:0] + scl_pkg::LinOffset;
        seg_a_q[l] <= (kprod[l] <= scl_pkg::LinLimit);
      end
    end
  end

  // pick the lower and upper table entries
  always_comb begin
    for (int l = 0; l < scl_pkg::Lanes; l++) begin
      e0[l]   = kodd_q[l] ? odd_q[l] : even_q[l];
      e1[l]   = kodd_q[l] ? even_q[l] : odd_q[l];
      step[l] = e1[l] - e0[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < scl_pkg::Lanes; l++) begin
        base_q[l]   <= e0[l];
        interp_q[l] <= scl_pkg::InterpBits'(step[l]) * scl_pkg::InterpBits'(frac_q[l]);
        quot_q[l]   <= scl_pkg::QuotBits'(num_q[l]) * scl_pkg::QuotBits'(scl_pkg::LinRecip);
        seg_b_q[l]  <= seg_a_q[l];
      end
    end
  end

  // linear segment below epsilon, interpolated cube root above
  always_comb begin
    for (int l = 0; l < scl_pkg::Lanes; l++) begin
      interp_rnd[l] = interp_q[l] + scl_pkg::InterpBits'(64);
      if (seg_b_q[l]) begin
        f_d[l] = scl_pkg::FBits'(quot_q[l][scl_pkg::QuotBits-1:scl_pkg::RecipShift]);
      end else begin
        f_d[l] = base_q[l] + scl_pkg::FBits'(interp_rnd[l] >> scl_pkg::CbrtStepBits);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= f_d;
    end
  end

  assign valid_o = valid_c_q;
  assign f_o     = f_q;

endmodule

// ===== design/scl_lab.sv =====
// lab scaling, rounding and saturation; the last stage is the output register
`include "srgb_to_cielab_top_macros.svh"

module scl_lab #(
  parameter int unsigned FractionBits = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  scl_pkg::fval_vec_t f_i,
  output logic               valid_o,
  output logic [14:0]        lightness_o,
  output logic [15:0]        a_axis_o,
  output logic [15:0]        b_axis_o
);

  localparam int unsigned Sh = 16 - FractionBits;
  localparam logic signed [scl_pkg::LabBits-1:0] RoundHalf =
    scl_pkg::LabBits'(1 << (Sh - 1));
  localparam logic signed [scl_pkg::LabBits-1:0] LightMax =
    scl_pkg::LabBits'(100 << FractionBits);
  localparam logic signed [scl_pkg::LabBits-1:0] AxisMax = 28'sd32767;
  localparam logic signed [scl_pkg::LabBits-1:0] AxisMin = -28'sd32768;

  logic signed [scl_pkg::LabBits-1:0] fx;
  logic signed [scl_pkg::LabBits-1:0] fy;
  logic signed [scl_pkg::LabBits-1:0] fz;
  logic signed [scl_pkg::LabBits-1:0] l_d;
  logic signed [scl_pkg::LabBits-1:0] a_d;
  logic signed [scl_pkg::LabBits-1:0] b_d;
  logic signed [scl_pkg::LabBits-1:0] l_q;
  logic signed [scl_pkg::LabBits-1:0] a_q;
  logic signed [scl_pkg::LabBits-1:0] b_q;
  logic                               mid_valid_q;

  logic signed [scl_pkg::LabBits-1:0] l_rnd;
  logic signed [scl_pkg::LabBits-1:0] a_rnd;
  logic signed [scl_pkg::LabBits-1:0] b_rnd;
  logic signed [scl_pkg::LabBits-1:0] l_sat;
  logic signed [scl_pkg::LabBits-1:0] a_sat;
  logic signed [scl_pkg::LabBits-1:0] b_sat;
  logic [14:0]                        lightness_d;
  logic [15:0]                        a_axis_d;
  logic [15:0]                        b_axis_d;
  logic [14:0]                        lightness_q;
  logic [15:0]                        a_axis_q;
  logic [15:0]                        b_axis_q;
  logic                               valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      valid_q     <= 1'b0;
    end else if (en_i) begin
      mid_valid_q <= valid_i;
      valid_q     <= mid_valid_q;
    end
  end

  // l = 116 fy - 16, a = 500 (fx - fy), b = 200 (fy - fz), all q16
  always_comb begin
    fx  = $signed(scl_pkg::LabBits'(f_i[0]));
    fy  = $signed(scl_pkg::LabBits'(f_i[1]));
    fz  = $signed(scl_pkg::LabBits'(f_i[2]));
    l_d = fy * 28'sd116 - 28'sd1048576;
    a_d = (fx - fy) * 28'sd500;
    b_d = (fy - fz) * 28'sd200;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q <= l_d;
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  // round half up to the output fraction, then saturate
  always_comb begin
    l_rnd = (l_q + RoundHalf) >>> Sh;
    a_rnd = (a_q + RoundHalf) >>> Sh;
    b_rnd = (b_q + RoundHalf) >>> Sh;

    if (l_rnd < 0) l_sat = '0;
    else if (l_rnd > LightMax) l_sat = LightMax;
    else l_sat = l_rnd;

    if (a_rnd < AxisMin) a_sat = AxisMin;
    else if (a_rnd > AxisMax) a_sat = AxisMax;
    else a_sat = a_rnd;

    if (b_rnd < AxisMin) b_sat = AxisMin;
    else if (b_rnd > AxisMax) b_sat = AxisMax;
    else b_sat = b_rnd;

    lightness_d = l_sat[14:0];
    a_axis_d    = a_sat[15:0];
    b_axis_d    = b_sat[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lightness_q <= lightness_d;
      a_axis_q    <= a_axis_d;
      b_axis_q    <= b_axis_d;
    end
  end

  assign valid_o     = valid_q;
  assign lightness_o = lightness_q;
  assign a_axis_o    = a_axis_q;
  assign b_axis_o    = b_axis_q;

  // a result in the last inner stage reaches the output when the pipe moves
  `SCL_ASSERT_NEXT(a_out_fill, mid_valid_q && en_i, valid_q, "result lost before output")
  // the pipe only halts while a result is waiting at the output
  `SCL_ASSERT_NOW(a_stall_full, !en_i, valid_q, "pipeline halted with empty output")
  // an inner stage keeps its result over a halt
  `SCL_ASSERT_NEXT(a_mid_hold, mid_valid_q && !en_i, mid_valid_q, "result dropped in halt")

endmodule

// ===== design/srgb_to_cielab_top.sv =====
// srgb to cie lab (d65) converter, eight-stage pipeline, one pixel per clock while not halted
//
//  channel  | dir | tdata fields (low bit first)              | tuser | tlast
//  s_axis   | in  | red[7:0] green[15:8] blue[23:16]          | -     | -
//  m_axis   | out | lightness[14:0] a_axis[30:15] b_axis[46:31], bit 47 zero | - | -
//
// a pixel enters every clock while the pipe is not halted, and results leave in input order
// stages: gamma rom, matrix products, matrix sums, cube root rom, interpolation
// and reciprocal products, companding select, lab scaling, round and saturate
// the whole pipe advances together; it halts only while a result waits at the
// output and the sink is not ready, so s_axis_tready follows m_axis_tready
// reset clears the valid bits only; all tables are constant and need no fill
module srgb_to_cielab_top #(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // red, green, blue
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o   // lightness, a_axis, b_axis, zero pad
);

  logic               en;
  logic               gam_valid;
  logic               mat_valid;
  logic               cmp_valid;
  logic               out_valid;
  scl_pkg::lin_vec_t  lin;
  scl_pkg::tval_vec_t tval;
  scl_pkg::fval_vec_t fval;
  logic [14:0]        lightness;
  logic [15:0]        a_axis;
  logic [15:0]        b_axis;

  // global advance: move unless the output holds a result nobody takes
  assign en              = !out_valid || m_axis_tready_i;
  assign s_axis_tready_o = en;

  scl_gamma #(
    .ChannelBits(CHANNEL_BITS)
  ) u_gamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .red_i   (s_axis_tdata_i[7:0]),
    .green_i (s_axis_tdata_i[15:8]),
    .blue_i  (s_axis_tdata_i[23:16]),
    .valid_o (gam_valid),
    .lin_o   (lin)
  );

  scl_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (gam_valid),
    .lin_i   (lin),
    .valid_o (mat_valid),
    .t_o     (tval)
  );

  scl_compand u_compand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mat_valid),
    .t_i     (tval),
    .valid_o (cmp_valid),
    .f_o     (fval)
  );

  scl_lab #(
    .FractionBits(FRACTION_BITS)
  ) u_lab (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (cmp_valid),
    .f_i         (fval),
    .valid_o     (out_valid),
    .lightness_o (lightness),
    .a_axis_o    (a_axis),
    .b_axis_o    (b_axis)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {1'b0, b_axis, a_axis, lightness};

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the srgb to cielab (d65) pixel converter
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] b_axis;
    logic signed [15:0] a_axis;
    logic [14:0]        lightness;
  } lab_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;

  srgb_to_cielab_top u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [23:0] pixel_q[$];
  lab_t        lab_q[$];
  longint      lin_tbl [256];
  longint      root_tbl [1025];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          fail_cnt = 0;

  // sRGB decode: linear segment near black, else t^2.4 as t^2 times a fifth root of t^2
  function automatic longint q30_pow5(longint w);
    longint w2;
    longint w4;
    w2 = (w * w) >> 30;
    w4 = (w2 * w2) >> 30;
    return (w4 * w) >> 30;
  endfunction

  function automatic longint decode_gamma(longint v);
    longint m;
    longint den;
    longint t;
    longint s;
    longint lo;
    longint hi;
    longint mid;
    m = 255;
    if (v * 100000 <= 4045 * m) return (v * 6553600 + 646 * m) / (1292 * m);
    den = 1055 * m;
    t = (((1000 * v + 55 * m) << 30) + den / 2) / den;
    if (t > (64'sd1 << 30)) t = 64'sd1 << 30;
    s = (t * t) >> 30;
    lo = 0;
    hi = 64'sd1 << 30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (q30_pow5(mid) <= s) lo = mid;
      else hi = mid - 1;
    end
    return (((s * lo) >> 30) + 8192) >> 14;
  endfunction

  // rounded cube root of k/512 in q16
  function automatic longint root_knot(longint k);
    longint n;
    longint lo;
    longint hi;
    longint mid;
    longint q;
    n = k << 39;
    lo = 0;
    hi = 131071;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    q = 2 * lo + 1;
    if (8 * n > q * q * q) lo++;
    return lo;
  endfunction

  // lab companding: kappa line below epsilon, interpolated cube root above
  function automatic longint lab_compand(longint t);
    longint k;
    longint r;
    if (t * 24389 <= 14155776) return (t * 24389 + 432 * 65536 + 1566) / 3132;
    if (t > 131071) t = 131071;
    k = t >> 7;
    r = t & 127;
    return root_tbl[k] + (((root_tbl[k+1] - root_tbl[k]) * r + 64) >> 7);
  endfunction

  function automatic longint q16_to_q8(longint v);
    return (v + 128) >>> 8;
  endfunction

  function automatic lab_t pixel_to_lab(logic [23:0] px);
    longint lr;
    longint lg;
    longint lb;
    longint fx;
    longint fy;
    longint fz;
    longint lv;
    longint av;
    longint bv;
    lab_t   res;
    lr = lin_tbl[px[7:0]];
    lg = lin_tbl[px[15:8]];
    lb = lin_tbl[px[23:16]];
    fx = lab_compand((28439 * lr + 24656 * lg + 12440 * lb + 32768) >> 16);
    fy = lab_compand((13938 * lr + 46869 * lg + 4730 * lb + 32768) >> 16);
    fz = lab_compand((1164 * lr + 7174 * lg + 57194 * lb + 32768) >> 16);
    lv = q16_to_q8(116 * fy - 16 * 65536);
    av = q16_to_q8(500 * (fx - fy));
    bv = q16_to_q8(200 * (fy - fz));
    lv = lv < 0 ? 0 : (lv > 25600 ? 25600 : lv);
    av = av < -32768 ? -32768 : (av > 32767 ? 32767 : av);
    bv = bv < -32768 ? -32768 : (bv > 32767 ? 32767 : bv);
    res.lightness = lv[14:0];
    res.a_axis    = av[15:0];
    res.b_axis    = bv[15:0];
    return res;
  endfunction

  // driver: offer the queue front, predict on each input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    logic acc;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      acc = s_axis_tvalid_i && s_axis_tready_o;
      if (acc) lab_q.push_back(pixel_to_lab(pixel_q.pop_front()));
      if (!s_axis_tvalid_i || acc) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pixel_q[0];
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // sink ready: random stalls, or a long counted hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    int hold_cnt;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_cnt = 0;
    end else if (hold_req) begin
      m_axis_tready_i <= 1'b0;
      hold_cnt++;
      if (hold_cnt == 300) begin
        hold_req = 1'b0;
        hold_cnt = 0;
      end
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin
    lab_t got;
    lab_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[46:0];
      if (lab_q.size() == 0) begin
        $error("result with no pixel outstanding: %h", m_axis_tdata_o);
        fail_cnt++;
      end else begin
        want = lab_q.pop_front();
        if (got.lightness !== want.lightness) begin
          $error("lightness: expected %0d, got %0d", want.lightness, got.lightness);
          fail_cnt++;
        end
        if (got.a_axis !== want.a_axis) begin
          $error("a_axis: expected %0d, got %0d", want.a_axis, got.a_axis);
          fail_cnt++;
        end
        if (got.b_axis !== want.b_axis) begin
          $error("b_axis: expected %0d, got %0d", want.b_axis, got.b_axis);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    int quiet;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet = 0;
    else
      quiet++;
    if (quiet >= 5000) begin
      $display("srgb_to_cielab_top test failed");
      $finish;
    end
  end

  task automatic drain();
    wait (pixel_q.size() == 0 && !s_axis_tvalid_i && lab_q.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic random_pixels(int n);
    logic [7:0] ch [3];
    repeat (n) begin
      foreach (ch[i]) begin
        case ($urandom_range(3))
          0:       ch[i] = 8'($urandom_range(0, 16));
          1:       ch[i] = 8'($urandom_range(240, 255));
          default: ch[i] = 8'($urandom_range(0, 255));
        endcase
      end
      pixel_q.push_back({ch[2], ch[1], ch[0]});
    end
  endtask

  initial begin
    logic [23:0] directed [] = '{
      24'h000000, 24'hffffff, 24'h0000ff, 24'h00ff00, 24'hff0000,
      24'h00ffff, 24'hff00ff, 24'hffff00, 24'h0a0a0a, 24'h0b0b0b,
      24'h010101, 24'hfefefe, 24'h808080, 24'h55aa55, 24'haa55aa,
      24'h0a0b0c, 24'hff0001, 24'h01ff00, 24'h0000fe, 24'h0b0000
    };
    for (int v = 0; v < 256; v++) lin_tbl[v] = decode_gamma(v);
    for (int k = 0; k <= 1024; k++) root_tbl[k] = root_knot(k);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) pixel_q.push_back(directed[i]);
    drain();

    // no idling
    random_pixels(383);
    drain();
    // sender gaps, with a long sink hold-off so the pipe backs up
    send_idle_pct = 48;
    hold_req = 1'b1;
    random_pixels(383);
    drain();
    // sink stalls
    send_idle_pct = 0;
    recv_stall_pct = 48;
    random_pixels(383);
    drain();
    // both sides idling
    send_idle_pct = 14;
    recv_stall_pct = 14;
    random_pixels(383);
    drain();

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("srgb_to_cielab_top test passed");
    end else begin
      $display("srgb_to_cielab_top test failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/scl_pkg.sv
design/scl_gamma.sv
design/scl_matrix.sv
design/scl_compand.sv
design/scl_lab.sv
design/srgb_to_cielab_top.sv
verif/testbench.sv
